@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the list engine checkers.
// Each expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset.
`define PLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that, when seen, forces another in the next cycle.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
package ple_pkg;

	// func codes
	localparam logic [2:0] FN_INSERT = 3'd0;
	localparam logic [2:0] FN_DELETE = 3'd1;
	localparam logic [2:0] FN_FIRST  = 3'd2;
	localparam logic [2:0] FN_LAST   = 3'd3;
	localparam logic [2:0] FN_COUNT  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADPOS   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam int DATA_W = 32;
	localparam int OUT_W  = 7;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INS,
		OP_DEL,
		OP_FIRST,
		OP_LAST,
		OP_CNT
	} op_t;

	typedef struct packed {
		logic       vld;
		op_t        op;
		logic [1:0] status;
	} ctl_t;

endpackage

@@ rtl/core/positional_list_engine_core.sv @@
// Ordered list of up to DEPTH signed 32-bit words held in a chain of DEPTH cells,
// one word per cell. Each request runs down the chain one cell per cycle while no
// response is stalled: insert and delete shift the cells at and past the position
// as the request passes, find-first, find-last and count collect their answer on
// the way. Requests may enter back to back, one per cycle while no response is
// stalled, and each one sees the list exactly as left by the one before it. The
// one exception is a delete directly behind an insert or delete: it pulls words up
// from the next cell, so it waits until the request ahead has left that cell. A
// response passes through DEPTH cell stages plus the response register. A stalled
// response freezes the whole chain, and req_stall rises while a response waits
// under stall, or while such a delete waits.
// Full and bad-position checks use the live count at entry; fill_level is the
// count after the operation, kept to its low 7 bits.
module positional_list_engine_core import ple_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	input  logic [6:0]         position,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic [6:0]         found_index,
	output logic [6:0]         fill_level
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > OUT_W) ? CW : OUT_W;

	logic          adv;
	logic          acc;
	logic          del_hold;
	logic [CW-1:0] count_q;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;

	ctl_t          e_ctl;
	logic [CW-1:0] e_fill;

	ctl_t              ch_ctl  [DEPTH+1];
	logic [CW-1:0]     ch_pos  [DEPTH+1];
	logic [CW-1:0]     ch_fill [DEPTH+1];
	logic [CW-1:0]     ch_res  [DEPTH+1];
	logic [DATA_W-1:0] ch_data [DEPTH+1];
	logic [DATA_W-1:0] ch_rem  [DEPTH+1];
	logic [DATA_W-1:0] cell_data [DEPTH];

	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] removed_q;
	logic [OUT_W-1:0]  found_q;
	logic [OUT_W-1:0]  fill_q;
	logic [1:0]        end_status;
	logic [PW-1:0]     end_res_w;
	logic [PW-1:0]     end_fill_w;

	assign adv = !rsp_valid_q || !rsp_stall;

	// a delete reads the next cell, which the insert or delete one stage ahead
	// has not written yet
	assign del_hold = (func == FN_DELETE) && ch_ctl[1].vld
			&& ((ch_ctl[1].op == OP_INS) || (ch_ctl[1].op == OP_DEL));

	assign req_stall = !adv || del_hold;
	assign acc       = req_valid && !req_stall;

	assign pos_w = PW'(position);
	assign cnt_w = PW'(count_q);

	always_comb begin
		e_ctl.vld    = acc;
		e_ctl.op     = OP_NOP;
		e_ctl.status = ST_BADPOS;
		e_fill       = count_q;
		case (func)
			FN_INSERT: begin
				if (count_q >= CW'(DEPTH)) begin
					e_ctl.status = ST_FULL;
				end else if ((pos_w == '0) || (pos_w > cnt_w + PW'(1))) begin
					e_ctl.status = ST_BADPOS;
				end else begin
					e_ctl.op     = OP_INS;
					e_ctl.status = ST_OK;
					e_fill       = count_q + CW'(1);
				end
			end
			FN_DELETE: begin
				if ((pos_w == '0) || (pos_w > cnt_w)) begin
					e_ctl.status = ST_BADPOS;
				end else begin
					e_ctl.op     = OP_DEL;
					e_ctl.status = ST_OK;
					e_fill       = count_q - CW'(1);
				end
			end
			FN_FIRST: begin
				e_ctl.op     = OP_FIRST;
				e_ctl.status = ST_OK;
			end
			FN_LAST: begin
				e_ctl.op     = OP_LAST;
				e_ctl.status = ST_OK;
			end
			FN_COUNT: begin
				e_ctl.op     = OP_CNT;
				e_ctl.status = ST_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= e_fill;
		end
	end

	// position is only used when in range, so it fits CW bits then
	assign ch_ctl[0]  = e_ctl;
	assign ch_pos[0]  = CW'(pos_w);
	assign ch_fill[0] = e_fill;
	assign ch_res[0]  = '0;
	assign ch_data[0] = value;
	assign ch_rem[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] nbr;

		if (i < DEPTH - 1) begin : g_mid
			assign nbr = cell_data[i+1];
		end else begin : g_last
			assign nbr = cell_data[i];
		end

		ple_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.up_ctl   (ch_ctl[i]),
			.up_pos   (ch_pos[i]),
			.up_fill  (ch_fill[i]),
			.up_res   (ch_res[i]),
			.up_data  (ch_data[i]),
			.up_rem   (ch_rem[i]),
			.nbr_data (nbr),
			.own_data (cell_data[i]),
			.dn_ctl   (ch_ctl[i+1]),
			.dn_pos   (ch_pos[i+1]),
			.dn_fill  (ch_fill[i+1]),
			.dn_res   (ch_res[i+1]),
			.dn_data  (ch_data[i+1]),
			.dn_rem   (ch_rem[i+1])
		);
	end

	assign end_res_w  = PW'(ch_res[DEPTH]);
	assign end_fill_w = PW'(ch_fill[DEPTH]);

	always_comb begin
		end_status = ch_ctl[DEPTH].status;
		if (((ch_ctl[DEPTH].op == OP_FIRST) || (ch_ctl[DEPTH].op == OP_LAST))
				&& (ch_res[DEPTH] == '0))
			end_status = ST_NOTFOUND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= ch_ctl[DEPTH].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q  <= end_status;
			removed_q <= ch_rem[DEPTH];
			found_q   <= end_res_w[OUT_W-1:0];
			fill_q    <= end_fill_w[OUT_W-1:0];
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign found_index   = found_q;
	assign fill_level    = fill_q;

endmodule

@@ rtl/core/ple_cell.sv @@
module ple_cell import ple_pkg::*; #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ctl_t              up_ctl,
	input  logic [CW-1:0]     up_pos,
	input  logic [CW-1:0]     up_fill,
	input  logic [CW-1:0]     up_res,
	input  logic [DATA_W-1:0] up_data,
	input  logic [DATA_W-1:0] up_rem,
	input  logic [DATA_W-1:0] nbr_data,
	output logic [DATA_W-1:0] own_data,
	output ctl_t              dn_ctl,
	output logic [CW-1:0]     dn_pos,
	output logic [CW-1:0]     dn_fill,
	output logic [CW-1:0]     dn_res,
	output logic [DATA_W-1:0] dn_data,
	output logic [DATA_W-1:0] dn_rem
);

	localparam logic [CW-1:0] POS_HERE = CW'(IDX + 1);
	localparam logic [CW-1:0] IDX_HERE = CW'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] nxt_data;
	logic [DATA_W-1:0] data_d;
	logic [DATA_W-1:0] rem_d;
	logic [CW-1:0]     res_d;
	logic              hit;

	ctl_t              ctl_s1;
	logic [CW-1:0]     pos_s1;
	logic [CW-1:0]     fill_s1;
	logic [CW-1:0]     res_s1;
	logic [DATA_W-1:0] data_s1;
	logic [DATA_W-1:0] rem_s1;

	// fill equals the live count for search words
	assign hit = (up_fill > IDX_HERE) && (data_q == up_data);

	always_comb begin
		nxt_data = data_q;
		data_d   = up_data;
		rem_d    = up_rem;
		res_d    = up_res;
		case (up_ctl.op)
			OP_INS: begin
				// swap: this cell takes the carried word, passes its old one on
				if (up_pos <= POS_HERE) begin
					nxt_data = up_data;
					data_d   = data_q;
				end
			end
			OP_DEL: begin
				if (up_pos == POS_HERE)
					rem_d = data_q;
				if (up_pos <= POS_HERE)
					nxt_data = nbr_data;
			end
			OP_FIRST: begin
				if (hit && (up_res == '0))
					res_d = POS_HERE;
			end
			OP_LAST: begin
				if (hit)
					res_d = POS_HERE;
			end
			OP_CNT: begin
				if (hit)
					res_d = up_res + CW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && up_ctl.vld)
			data_q <= nxt_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1  <= up_pos;
			fill_s1 <= up_fill;
			res_s1  <= res_d;
			data_s1 <= data_d;
			rem_s1  <= rem_d;
		end
	end

	assign own_data = data_q;
	assign dn_ctl   = ctl_s1;
	assign dn_pos   = pos_s1;
	assign dn_fill  = fill_s1;
	assign dn_res   = res_s1;
	assign dn_data  = data_s1;
	assign dn_rem   = rem_s1;

endmodule

@@ rtl/core/ple_checker.sv @@
`include "assert_macros.svh"

module ple_checker import ple_pkg::*; #(
	parameter int DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [1:0]         status,
	input logic signed [31:0] removed_value,
	input logic [6:0]         found_index,
	input logic [6:0]         fill_level
);

	// without a held response, a request stall clears in the next cycle unless a response is then held
	`PLE_ASSERT_NEXT(a_stall_cause, req_stall && !(rsp_valid && rsp_stall), !req_stall || (rsp_valid && rsp_stall), "req stall too long")

	`PLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(removed_value) && $stable(fill_level), "stalled rsp word changed")

	`PLE_ASSERT(a_rem_ok, !rsp_valid || (removed_value == 0) || (status == ST_OK), "removed word on failed op")

	`PLE_ASSERT(a_idx_fail, !rsp_valid || !(status == ST_NOTFOUND || status == ST_FULL) || (found_index == 0), "index on failed op")

	`PLE_ASSERT(a_fill_max, !rsp_valid || !req_valid || (fill_level <= DEPTH), "fill above depth")

endmodule

bind positional_list_engine_core ple_checker #(
	.DEPTH (DEPTH)
) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_stall     (req_stall),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.status        (status),
	.removed_value (removed_value),
	.found_index   (found_index),
	.fill_level    (fill_level)
);
